// File: rtl/bipbuf_pkg.sv
// Shared types and codes for the bip buffer grant manager.
// Depends on nothing; every other file of the block imports it.
package bipbuf_pkg;

    // Width of lengths, offsets and pointers.
    localparam int unsigned PTR_W = 13;

    // Default upper bound on the usable buffer size.
    localparam int unsigned DEFAULT_MAX_DEPTH = 4096;

    // Reset value of the buffer size register.
    localparam logic [PTR_W-1:0] SIZE_RESET = 13'd4096;

    // Request operation codes.
    localparam logic [2:0] MODE_GRANT_EXACT = 3'd0;
    localparam logic [2:0] MODE_GRANT_MAX   = 3'd1;
    localparam logic [2:0] MODE_COMMIT      = 3'd2;
    localparam logic [2:0] MODE_READ_GRANT  = 3'd3;
    localparam logic [2:0] MODE_RELEASE     = 3'd4;

    // One request on the input channel.
    typedef struct packed {
        logic [2:0]       mode;
        logic [PTR_W-1:0] req_length;
    } req_t;

    // One result on the output channel.
    typedef struct packed {
        logic             ok;
        logic [PTR_W-1:0] region_offset;
        logic [PTR_W-1:0] region_length;
    } rsp_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_HOLD
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_req;
        logic execute;
    } cmd_t;

endpackage

// File: rtl/bipbuf_ctrl.sv
// Handshake controller of the bip buffer grant manager.
// Depends on bipbuf_pkg; drives the command struct of bipbuf_datapath.
module bipbuf_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output bipbuf_pkg::cmd_t   cmd
);
    import bipbuf_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   take;

    // A new request is taken when idle, or when the waiting result leaves.
    assign take = in_valid && in_ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (out_ready)
                begin
                    state_next = take ? ST_EXEC : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and commands.
    always_comb
    begin
        in_ready     = 1'b0;
        out_valid    = 1'b0;
        cmd.execute  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_EXEC:
            begin
                cmd.execute = 1'b1;
            end
            ST_HOLD:
            begin
                out_valid = 1'b1;
                in_ready  = out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
        cmd.load_req = take;
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/bipbuf_datapath.sv
// Pointer datapath of the bip buffer grant manager: pointers, flags,
// grant lengths, request and result registers. Depends on bipbuf_pkg.
module bipbuf_datapath #(
    parameter int unsigned MAX_DEPTH = bipbuf_pkg::DEFAULT_MAX_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bipbuf_pkg::cmd_t             cmd,
    input  bipbuf_pkg::req_t             in_data,
    input  logic                         cfg_we,
    input  logic [bipbuf_pkg::PTR_W-1:0] cfg_data,
    output bipbuf_pkg::rsp_t             out_data
);
    import bipbuf_pkg::*;

    // Largest size the 13-bit register can express, bounded by MAX_DEPTH.
    localparam int unsigned PTR_MAX = (1 << PTR_W) - 1;
    localparam logic [PTR_W-1:0] CAP =
        PTR_W'((MAX_DEPTH > PTR_MAX) ? PTR_MAX : MAX_DEPTH);

    logic [PTR_W-1:0] size_reg;
    logic [PTR_W-1:0] wpos_reg, wpos_next;
    logic [PTR_W-1:0] rpos_reg, rpos_next;
    logic [PTR_W-1:0] lpos_reg, lpos_next;
    logic [PTR_W-1:0] rsv_reg, rsv_next;
    logic             wbusy_reg, wbusy_next;
    logic             rbusy_reg, rbusy_next;
    logic [PTR_W-1:0] wlen_reg, wlen_next;
    logic [PTR_W-1:0] rlen_reg, rlen_next;
    req_t             req_reg;
    rsp_t             rsp_reg, rsp_next;

    logic [PTR_W-1:0] max_sz;
    logic [PTR_W:0]   wsum;
    logic [PTR_W-1:0] len;
    logic [PTR_W-1:0] remain;
    logic [PTR_W-1:0] tail;
    logic [PTR_W-1:0] head;
    logic [PTR_W-1:0] used_w;
    logic [PTR_W-1:0] gap;
    logic [PTR_W-1:0] new_w;
    logic [PTR_W-1:0] rp_eff;
    logic [PTR_W-1:0] rend;
    logic [PTR_W-1:0] rsz;
    logic [PTR_W-1:0] used_r;
    logic             grant;
    logic [PTR_W-1:0] start;
    logic [PTR_W-1:0] gsz;

    // Size in use, clamped to one and to the capacity bound.
    always_comb
    begin
        if (size_reg == '0)
        begin
            max_sz = PTR_W'(1);
        end
        else if (size_reg > CAP)
        begin
            max_sz = CAP;
        end
        else
        begin
            max_sz = size_reg;
        end
    end

    // Shared arithmetic on the registered pointers.
    always_comb
    begin
        len    = req_reg.req_length;
        wsum   = {1'b0, wpos_reg} + {1'b0, len};
        remain = rpos_reg - wpos_reg - PTR_W'(1);
        tail   = max_sz - wpos_reg;
        head   = rpos_reg - PTR_W'(1);
        used_w = (wlen_reg < len) ? wlen_reg : len;
        gap    = wlen_reg - used_w;
        new_w  = (rsv_reg > gap) ? (rsv_reg - gap) : '0;
        rp_eff = ((rpos_reg == lpos_reg) && (wpos_reg < rpos_reg)) ? '0 : rpos_reg;
        rend   = (wpos_reg < rp_eff) ? lpos_reg : wpos_reg;
        rsz    = (rend > rp_eff) ? (rend - rp_eff) : '0;
        used_r = (rlen_reg < len) ? rlen_reg : len;
    end

    // Write grant decision.
    always_comb
    begin
        grant = 1'b0;
        start = '0;
        gsz   = len;
        if (wpos_reg < rpos_reg)
        begin
            if (req_reg.mode == MODE_GRANT_EXACT)
            begin
                if (wsum < {1'b0, rpos_reg})
                begin
                    start = wpos_reg;
                    grant = 1'b1;
                end
            end
            else if (remain != '0)
            begin
                gsz   = (remain < len) ? remain : len;
                start = wpos_reg;
                grant = 1'b1;
            end
        end
        else if (req_reg.mode == MODE_GRANT_EXACT)
        begin
            if (wsum <= {1'b0, max_sz})
            begin
                start = wpos_reg;
                grant = 1'b1;
            end
            else if (len < rpos_reg)
            begin
                grant = 1'b1;
            end
        end
        else if (wpos_reg < max_sz)
        begin
            gsz   = (tail < len) ? tail : len;
            start = wpos_reg;
            grant = 1'b1;
        end
        else if (rpos_reg > PTR_W'(1))
        begin
            gsz   = (head < len) ? head : len;
            grant = 1'b1;
        end
    end

    // State update and result for the request under execution.
    always_comb
    begin
        wpos_next  = wpos_reg;
        rpos_next  = rpos_reg;
        lpos_next  = lpos_reg;
        rsv_next   = rsv_reg;
        wbusy_next = wbusy_reg;
        rbusy_next = rbusy_reg;
        wlen_next  = wlen_reg;
        rlen_next  = rlen_reg;
        rsp_next   = '0;
        case (req_reg.mode)
            MODE_GRANT_EXACT, MODE_GRANT_MAX:
            begin
                if (!wbusy_reg && grant)
                begin
                    wbusy_next             = 1'b1;
                    rsv_next               = start + gsz;
                    wlen_next              = gsz;
                    rsp_next.ok            = 1'b1;
                    rsp_next.region_offset = start;
                    rsp_next.region_length = gsz;
                end
            end
            MODE_COMMIT:
            begin
                if (wbusy_reg)
                begin
                    // A commit that moves backward marks where the data wraps.
                    if ((new_w < wpos_reg) && (wpos_reg != max_sz))
                    begin
                        lpos_next = wpos_reg;
                    end
                    else if (new_w > lpos_reg)
                    begin
                        lpos_next = max_sz;
                    end
                    wpos_next   = new_w;
                    rsv_next    = new_w;
                    wbusy_next  = 1'b0;
                    wlen_next   = '0;
                    rsp_next.ok = 1'b1;
                end
            end
            MODE_READ_GRANT:
            begin
                if (!rbusy_reg)
                begin
                    // The wrap of the read pointer is kept even with no data.
                    rpos_next = rp_eff;
                    if (rsz != '0)
                    begin
                        rbusy_next             = 1'b1;
                        rlen_next              = rsz;
                        rsp_next.ok            = 1'b1;
                        rsp_next.region_offset = rp_eff;
                        rsp_next.region_length = rsz;
                    end
                end
            end
            MODE_RELEASE:
            begin
                if (rbusy_reg)
                begin
                    rpos_next   = rpos_reg + used_r;
                    rbusy_next  = 1'b0;
                    rlen_next   = '0;
                    rsp_next.ok = 1'b1;
                end
            end
            default:
            begin
                rsp_next = '0;
            end
        endcase
    end

    // Pointer, flag and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg  <= SIZE_RESET;
            wpos_reg  <= '0;
            rpos_reg  <= '0;
            lpos_reg  <= '0;
            rsv_reg   <= '0;
            wbusy_reg <= 1'b0;
            rbusy_reg <= 1'b0;
            wlen_reg  <= '0;
            rlen_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                size_reg <= cfg_data;
            end
            if (cmd.execute)
            begin
                wpos_reg  <= wpos_next;
                rpos_reg  <= rpos_next;
                lpos_reg  <= lpos_next;
                rsv_reg   <= rsv_next;
                wbusy_reg <= wbusy_next;
                rbusy_reg <= rbusy_next;
                wlen_reg  <= wlen_next;
                rlen_reg  <= rlen_next;
            end
        end
    end

    // Request and result payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= in_data;
        end
        if (cmd.execute)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign out_data = rsp_reg;

endmodule

// File: rtl/bip_buffer_grant_manager_top.sv
// Top level of the bip buffer grant manager.
// Depends on bipbuf_pkg, bipbuf_ctrl and bipbuf_datapath.
//
// Usage:
//   The input channel (in_valid, in_ready, in_data) carries one request:
//   an operation code and a length. The output channel (out_valid,
//   out_ready, out_data) returns exactly one result per request: ok,
//   region offset and region length.
//   A request is registered at acceptance, executed against the pointer
//   registers in the following cycle, and its result is shown from the
//   cycle after that in an output register. out_valid rises when the
//   controller moves from its execute state to its hold state. A new
//   request may be accepted in the same cycle in which the waiting
//   result is taken; the execute state, in which the controller updates
//   the pointers before the next request is read, keeps in_ready low.
//   While the receiver stalls, the result holds and in_ready stays low.
//   Reset clears all pointers, busy flags and grant lengths and sets the
//   buffer size to 4096. cfg_we writes the buffer size; write it only idle.
module bip_buffer_grant_manager_top #(
    parameter int unsigned MAX_DEPTH = bipbuf_pkg::DEFAULT_MAX_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  bipbuf_pkg::req_t             in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output bipbuf_pkg::rsp_t             out_data,
    input  logic                         cfg_we,
    input  logic [bipbuf_pkg::PTR_W-1:0] cfg_data
);
    import bipbuf_pkg::*;

    cmd_t cmd;

    // Handshake sequencing.
    bipbuf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // Pointer arithmetic and state.
    bipbuf_datapath #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_data  (in_data),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .out_data (out_data)
    );

endmodule

// File: rtl/bipbuf_checker.sv
// Port-level checks of the bip buffer grant manager, bound to the top level.
// Depends on bipbuf_pkg and bip_buffer_grant_manager_top.
module bipbuf_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input bipbuf_pkg::rsp_t out_data
);
    import bipbuf_pkg::*;

    // A stalled result keeps its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // A new request is never taken while a result stays stalled.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready && out_valid |-> out_ready)
        else $error("request taken while result stalled");

    // After a request is accepted, the block executes before anything else.
    a_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !out_valid && !in_ready)
        else $error("accepted request not executed");

    // A failed request reports an empty region.
    a_empty_fail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.ok |->
            out_data.region_offset == '0 && out_data.region_length == '0)
        else $error("failed request reports a region");

endmodule

bind bip_buffer_grant_manager_top bipbuf_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
